### hw/rtl/radix_text_to_integer_assert.svh
// Assertion macros shared by the radix text converter RTL.
`ifndef RADIX_TEXT_TO_INTEGER_ASSERT_SVH
`define RADIX_TEXT_TO_INTEGER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define RTTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When cond holds, sig holds its value into the next cycle.
`define RTTI_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

### hw/rtl/rtti_pkg.sv
// Types and constants of the radix text-to-integer converter.
package rtti_pkg;

  localparam int unsigned AlphaChars = 16;
  localparam int unsigned MaxRadix   = 16;
  localparam int unsigned DigitW     = $clog2(AlphaChars);
  localparam int unsigned RadixW     = 5;
  localparam int unsigned CharW      = 8;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 2;

  // Reset alphabet "0123456789", radix 10
  localparam logic [CfgDataW-1:0] AlphaLowRst  = 64'h3736_3534_3332_3130;
  localparam logic [CfgDataW-1:0] AlphaHighRst = 64'h0000_0000_0000_3938;
  localparam logic [RadixW-1:0]   RadixRst     = 5'd10;

  // Character codes
  localparam logic [CharW-1:0] ChPlus    = 8'h2B;
  localparam logic [CharW-1:0] ChMinus   = 8'h2D;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChCr      = 8'h0D;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChPrintLo = 8'd33;
  localparam logic [CharW-1:0] ChPrintHi = 8'd126;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgAlphaLow  = 2'd0,
    CfgAlphaHigh = 2'd1,
    CfgRadixLen  = 2'd2
  } cfg_reg_e;

  // Scan phase, one-hot
  typedef enum logic [3:0] {
    PhSpace = 4'b0001,
    PhSign  = 4'b0010,
    PhDigit = 4'b0100,
    PhDone  = 4'b1000
  } phase_e;

  // Digit lookup result
  typedef struct packed {
    logic              hit;
    logic [DigitW-1:0] idx;
  } digit_t;

endpackage

### hw/rtl/radix_text_to_integer.sv
// Radix text-to-integer converter: top level with scan logic and stream ports.
//
// Converts a byte string, one character per item, into a signed 32-bit
// integer in a radix of 2 to 16 whose digit characters are set in the
// alphabet registers. Leading whitespace is skipped, a run of '+'/'-' sets
// the sign, digits accumulate until the first other byte, and the item with
// tlast produces one result item (value wraps modulo 2^32; an invalid
// alphabet gives value 0 and a cleared tuser flag). One item is accepted
// every cycle unless the input stalls; each item waits in the input
// register and is then folded into the accumulator by a single
// multiply-by-radix and add; the last item's result goes into the output
// register. Input stalls only while a finished result waits in the output
// register and another last item waits in the input register. Configuration
// may be written only while no string is in flight.
module radix_text_to_integer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rtti_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtti_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] char_code
  input  logic                          s_axis_tlast_i,   // is_last
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [31:0]                   m_axis_tdata_o,   // [31:0] value
  output logic                          m_axis_tuser_o    // [0] alphabet_ok
);
  import rtti_pkg::*;
  `include "radix_text_to_integer_assert.svh"

  // Configuration registers
  logic [CfgDataW-1:0] alpha_low_q, alpha_high_q;
  logic [RadixW-1:0]   radix_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= AlphaLowRst;
      alpha_high_q <= AlphaHighRst;
      radix_len_q  <= RadixRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgAlphaLow:  alpha_low_q  <= cfg_data_i;
        CfgAlphaHigh: alpha_high_q <= cfg_data_i;
        CfgRadixLen:  radix_len_q  <= cfg_data_i[RadixW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake
  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;
  logic             out_free, advance, load_out;

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign advance         = in_valid_q && (!in_last_q || out_free);
  assign load_out        = advance && in_last_q;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Alphabet lookup and validity
  digit_t            digit;
  logic [RadixW-1:0] radix;
  logic              alpha_ok;

  rtti_alphabet u_alphabet (
    .alpha_low_i  (alpha_low_q),
    .alpha_high_i (alpha_high_q),
    .radix_len_i  (radix_len_q),
    .char_i       (in_char_q),
    .digit_o      (digit),
    .radix_o      (radix),
    .ok_o         (alpha_ok)
  );

  // Scan state
  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic [ValueW+RadixW-1:0] prod;
  logic                is_space, is_sign;
  logic [ValueW-1:0]   value_d;

  assign is_space = (in_char_q >= ChTab && in_char_q <= ChCr) || in_char_q == ChSpace;
  assign is_sign  = in_char_q == ChPlus || in_char_q == ChMinus;
  assign prod     = acc_q * radix;

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    unique case (phase_q)
      PhSpace, PhSign, PhDigit: begin
        if (phase_q == PhSpace && is_space) begin
          phase_d = PhSpace;
        end else if (phase_q != PhDigit && is_sign) begin
          phase_d = PhSign;
          if (in_char_q == ChMinus) begin
            neg_d = !neg_q;
          end
        end else if (digit.hit) begin
          phase_d = PhDigit;
          acc_d   = prod[ValueW-1:0] + ValueW'(digit.idx);
        end else begin
          phase_d = PhDone;
        end
      end
      PhDone:  phase_d = PhDone;
      default: phase_d = PhSpace;
    endcase
  end

  // Signed result of the finished string
  always_comb begin
    if (!alpha_ok) begin
      value_d = '0;
    end else if (neg_d) begin
      value_d = '0 - acc_d;
    end else begin
      value_d = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSpace;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (load_out) begin
      phase_q <= PhSpace;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
    end
  end

  // Output register
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= value_d;
      out_ok_q    <= alpha_ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_ok_q;

  // Checks
  `RTTI_ASSERT(a_result_from_last, (out_valid_q && !$past(out_valid_q)) |-> $past(in_valid_q && in_last_q), "result without last item")
  `RTTI_ASSERT(a_clear_after_last, load_out |=> (phase_q == PhSpace && !neg_q && acc_q == '0), "scan state not cleared after last item")
  `RTTI_ASSERT(a_invalid_is_zero, (out_valid_q && !out_ok_q) |-> (out_value_q == '0), "invalid alphabet with nonzero value")
  `RTTI_ASSERT_HOLD(a_scan_hold, !advance, acc_q, "accumulator moved without an item")

endmodule

### hw/rtl/rtti_alphabet.sv
// Alphabet lookup of one character and validity check of the alphabet.
module rtti_alphabet (
  input  logic [rtti_pkg::CfgDataW-1:0] alpha_low_i,
  input  logic [rtti_pkg::CfgDataW-1:0] alpha_high_i,
  input  logic [rtti_pkg::RadixW-1:0]   radix_len_i,
  input  logic [rtti_pkg::CharW-1:0]    char_i,
  output rtti_pkg::digit_t              digit_o,
  output logic [rtti_pkg::RadixW-1:0]   radix_o,
  output logic                          ok_o
);
  import rtti_pkg::*;

  logic [AlphaChars-1:0][CharW-1:0] chars;
  logic [AlphaChars-1:0]            in_use;
  logic [RadixW-1:0]                radix_use;

  assign chars = {alpha_high_i, alpha_low_i};

  // Radix clamped to the alphabet size
  always_comb begin
    if (radix_len_i > RadixW'(MaxRadix)) begin
      radix_use = RadixW'(MaxRadix);
    end else begin
      radix_use = radix_len_i;
    end
  end
  assign radix_o = radix_use;

  always_comb begin
    for (int k = 0; k < AlphaChars; k++) begin
      in_use[k] = RadixW'(k) < radix_use;
    end
  end

  // First matching character wins
  always_comb begin
    digit_o = '0;
    for (int k = AlphaChars - 1; k >= 0; k--) begin
      if (in_use[k] && chars[k] == char_i) begin
        digit_o.hit = 1'b1;
        digit_o.idx = DigitW'(k);
      end
    end
  end

  // Validity: length, printable non-sign characters, no repeats among the characters in use
  always_comb begin
    ok_o = (radix_len_i >= RadixW'(2)) && (radix_len_i <= RadixW'(MaxRadix));
    for (int i = 0; i < AlphaChars; i++) begin
      if (in_use[i]) begin
        if (chars[i] == ChPlus || chars[i] == ChMinus ||
            chars[i] < ChPrintLo || chars[i] > ChPrintHi) begin
          ok_o = 1'b0;
        end
        for (int j = i + 1; j < AlphaChars; j++) begin
          if (in_use[j] && chars[j] == chars[i]) begin
            ok_o = 1'b0;
          end
        end
      end
    end
  end

endmodule
